@@ src/chw_pkg.sv @@
package chw_pkg;

  // Sizes of the counter stores and of the word history.
  localparam int HIST_ENTRIES = 95;
  localparam int NUM_WORDS    = 5;
  localparam int MAX_WORD_LEN = 6;
  localparam int COUNT_WIDTH  = 32;

  localparam int FIRST_PRINTABLE = 32;
  localparam int LAST_PRINTABLE  = 126;
  localparam int HIST_DEPTH      = MAX_WORD_LEN + 1;
  localparam int SEEN_W          = $clog2(HIST_DEPTH + 1);
  localparam int HIST_AW         = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;

  // Field widths of the channels.
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 7;
  localparam int OUT_W  = 32;
  localparam int LEN_W  = 3;
  localparam int WORD_W = 48;
  localparam int LENS_W = 15;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 48;

  // Register indexes: words 0 to NUM_WORDS-1, then the length register.
  localparam int REG_LENGTHS = NUM_WORDS;

  // Command queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t WORD_RESET [NUM_WORDS] = '{
    48'd6581857, 48'd29793, 48'd29801, 48'd31085, 48'd127978959626568
  };
  localparam logic [LENS_W-1:0] LENS_RESET = 15'd25747;

  typedef enum logic [OP_W-1:0] {
    OP_TEXT  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_e                    op;
    logic                   hist_hit;
    logic [HIST_AW-1:0]     addr;
    logic [NUM_WORDS-1:0]   word_hit;
    logic [IDX_W-1:0]       idx;
  } cmd_t;

  function automatic logic is_letter(logic [BYTE_W-1:0] c);
    return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
           ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
  endfunction

endpackage

@@ src/chw_if.sv @@
interface chw_in_if;
  logic                         valid;
  logic                         ready;
  logic [chw_pkg::OP_W-1:0]     operation;
  logic [chw_pkg::BYTE_W-1:0]   data_byte;
  logic [chw_pkg::IDX_W-1:0]    counter_index;

  modport source (output valid, operation, data_byte, counter_index, input ready);
  modport sink (input valid, operation, data_byte, counter_index, output ready);
endinterface

interface chw_out_if;
  logic                         valid;
  logic                         ready;
  logic [chw_pkg::OUT_W-1:0]    count_value;
  logic [chw_pkg::IDX_W-1:0]    counter_echo;

  modport source (output valid, count_value, counter_echo, input ready);
  modport sink (input valid, count_value, counter_echo, output ready);
endinterface

interface chw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [chw_pkg::CFG_AW-1:0]   index;
  logic [chw_pkg::CFG_DW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/char_histogram_word_counter_top.sv @@
// A read item passes from the command queue through the stage register into the output
// register, where its result is shown.
// Throughput: one item per cycle, stalling only when the four-entry queue is full.
// Reset (asynchronous, active low) empties the queue and history, zeroes the word counters,
// clears the histogram at once through per-entry valid bits, and loads the register reset values.
module char_histogram_word_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  chw_in_if.sink      in_i,
  chw_cfg_if.sink     cfg_i,
  chw_out_if.source   out_o
);
  import chw_pkg::*;

  // The front end keeps the configured words and the last few text bytes. It
  // classifies every item as it is accepted: a text byte becomes a histogram
  // address plus a vector of words that end just before it, end of text
  // becomes the word vector alone, and read and clear items pass through with
  // their index. The word compares are made against the history in parallel,
  // so a whole item is classified in the cycle it arrives.
  cmd_t cmd;
  logic push;
  logic full;

  // The command queue lets the front keep taking items while the back end
  // waits on a stalled output.
  cmd_t head;
  logic pop;
  logic empty;

  chw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .cmd_o  (cmd),
    .push_o (push),
    .full_i (full)
  );

  chw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  // The back end holds the histogram in a memory with a registered read port.
  // Each item reads its entry as it leaves the queue and writes the
  // incremented value as it leaves the stage register; a write to the same
  // entry on the edge of the read is forwarded. Word counters sit in
  // flip-flops, and the result of a read item waits in an output register.
  chw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ src/chw_front.sv @@
module chw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  chw_in_if.sink         in_i,
  chw_cfg_if.sink        cfg_i,
  output chw_pkg::cmd_t  cmd_o,
  output logic           push_o,
  input  logic           full_i
);
  import chw_pkg::*;

  word_t                word_q [NUM_WORDS];
  logic [LENS_W-1:0]    lens_q;
  logic [BYTE_W-1:0]    hist_q [HIST_DEPTH];
  logic [SEEN_W-1:0]    seen_q;
  logic [NUM_WORDS-1:0] match;
  op_e                  op;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && in_i.ready;
  assign op          = op_e'(in_i.operation);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        word_q[w] <= WORD_RESET[w];
      end
      lens_q <= LENS_RESET;
    end else if (cfg_i.valid) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        if (cfg_i.index == CFG_AW'(w)) begin
          word_q[w] <= cfg_i.data[WORD_W-1:0];
        end
      end
      if (cfg_i.index == CFG_AW'(REG_LENGTHS)) begin
        lens_q <= cfg_i.data[LENS_W-1:0];
      end
    end
  end

  // Every word is compared against each possible length in parallel and the
  // configured length picks the answer, so all history taps are fixed.
  always_comb begin
    logic [LEN_W-1:0] len;
    logic             ok;
    match = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      len = lens_q[LEN_W*w +: LEN_W];
      for (int l = 1; l <= MAX_WORD_LEN; l++) begin
        ok = 1'b1;
        for (int k = 0; k < l; k++) begin
          if (hist_q[l-1-k] != word_q[w][BYTE_W*k +: BYTE_W]) begin
            ok = 1'b0;
          end
        end
        if ((int'(seen_q) > l) && is_letter(hist_q[l])) begin
          ok = 1'b0;
        end
        if ((int'(len) == l) && (int'(seen_q) >= l) && ok) begin
          match[w] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op;
    cmd_o.idx      = in_i.counter_index;
    case (op)
      OP_TEXT: begin
        cmd_o.hist_hit = (int'(in_i.data_byte) >= FIRST_PRINTABLE) &&
                         (int'(in_i.data_byte) <= LAST_PRINTABLE) &&
                         ((int'(in_i.data_byte) - FIRST_PRINTABLE) < HIST_ENTRIES);
        cmd_o.addr     = HIST_AW'(in_i.data_byte - BYTE_W'(FIRST_PRINTABLE));
        cmd_o.word_hit = is_letter(in_i.data_byte) ? '0 : match;
      end
      OP_END: begin
        cmd_o.word_hit = match;
      end
      OP_READ: begin
        cmd_o.hist_hit = int'(in_i.counter_index) < HIST_ENTRIES;
        cmd_o.addr     = HIST_AW'(in_i.counter_index);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < HIST_DEPTH; j++) begin
        hist_q[j] <= '0;
      end
      seen_q <= '0;
    end else if (push_o) begin
      case (op)
        OP_TEXT: begin
          for (int j = HIST_DEPTH - 1; j > 0; j--) begin
            hist_q[j] <= hist_q[j-1];
          end
          hist_q[0] <= in_i.data_byte;
          if (int'(seen_q) < HIST_DEPTH) begin
            seen_q <= seen_q + 1'b1;
          end
        end
        OP_END, OP_CLEAR: begin
          for (int j = 0; j < HIST_DEPTH; j++) begin
            hist_q[j] <= '0;
          end
          seen_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ src/chw_fifo.sv @@
module chw_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  chw_pkg::cmd_t  cmd_i,
  input  logic           pop_i,
  output chw_pkg::cmd_t  head_o,
  output logic           full_o,
  output logic           empty_o
);
  import chw_pkg::*;

  cmd_t                 slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q;
  logic [FIFO_AW-1:0]   rd_ptr_q;
  logic [FIFO_AW:0]     cnt_q;

  assign full_o  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/chw_back.sv @@
module chw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  chw_pkg::cmd_t  head_i,
  input  logic           empty_i,
  output logic           pop_o,
  chw_out_if.source      out_o
);
  import chw_pkg::*;

  logic [COUNT_WIDTH-1:0]  mem [HIST_ENTRIES];
  logic [HIST_ENTRIES-1:0] hvalid_q;
  logic [COUNT_WIDTH-1:0]  wcnt_q [NUM_WORDS];
  cmd_t                    s2_q;
  logic                    s2_vld_q;
  logic [COUNT_WIDTH-1:0]  rd_q;
  logic                    fwd_hit_q;
  logic [COUNT_WIDTH-1:0]  fwd_data_q;
  logic                    out_vld_q;
  logic [COUNT_WIDTH-1:0]  out_cnt_q;
  logic [IDX_W-1:0]        out_echo_q;

  logic                    adv;
  logic                    wr_en;
  logic                    is_read;
  logic [COUNT_WIDTH-1:0]  cur;
  logic [COUNT_WIDTH-1:0]  inc;
  logic [COUNT_WIDTH-1:0]  word_val;
  logic [COUNT_WIDTH-1:0]  rd_val;

  assign adv     = !out_vld_q || out_o.ready;
  assign pop_o   = adv && !empty_i;
  assign is_read = s2_vld_q && (s2_q.op == OP_READ);
  assign wr_en   = adv && s2_vld_q && (s2_q.op == OP_TEXT) && s2_q.hist_hit;

  // The entry written on the edge that issued this read is taken from the
  // forward register; an entry not written since the last clear reads zero.
  always_comb begin
    if (fwd_hit_q) begin
      cur = fwd_data_q;
    end else if (s2_q.hist_hit && hvalid_q[s2_q.addr]) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
    inc = (cur == COUNT_MAX) ? cur : cur + 1'b1;
  end

  always_comb begin
    word_val = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (int'(s2_q.idx) == HIST_ENTRIES + w) begin
        word_val = wcnt_q[w];
      end
    end
    rd_val = s2_q.hist_hit ? cur : word_val;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_q.addr] <= inc;
    end
    if (pop_o) begin
      rd_q <= mem[head_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q       <= head_i;
      fwd_data_q <= inc;
    end
    if (adv && is_read) begin
      out_cnt_q  <= rd_val;
      out_echo_q <= s2_q.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
      out_vld_q <= 1'b0;
      hvalid_q  <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        wcnt_q[w] <= '0;
      end
    end else if (adv) begin
      s2_vld_q  <= pop_o;
      fwd_hit_q <= wr_en && pop_o && (head_i.addr == s2_q.addr);
      out_vld_q <= is_read;
      if (s2_vld_q && (s2_q.op == OP_CLEAR)) begin
        hvalid_q <= '0;
        for (int w = 0; w < NUM_WORDS; w++) begin
          wcnt_q[w] <= '0;
        end
      end else if (s2_vld_q) begin
        if (wr_en) begin
          hvalid_q[s2_q.addr] <= 1'b1;
        end
        for (int w = 0; w < NUM_WORDS; w++) begin
          if (s2_q.word_hit[w] && (wcnt_q[w] != COUNT_MAX)) begin
            wcnt_q[w] <= wcnt_q[w] + 1'b1;
          end
        end
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.count_value  = OUT_W'(out_cnt_q);
  assign out_o.counter_echo = out_echo_q;

endmodule

@@ src/chw_checker.sv @@
module chw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [chw_pkg::OUT_W-1:0]   out_count_i,
  input logic [chw_pkg::IDX_W-1:0]   out_echo_i
);
  import chw_pkg::*;

  // A result that is held back stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A result that is held back keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_count_i) && $stable(out_echo_i))
    else $error("result payload changed while stalled");

  // An index past the last word counter reads zero.
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (int'(out_echo_i) >= HIST_ENTRIES + NUM_WORDS) |-> out_count_i == '0)
    else $error("unknown counter index gave a nonzero count");

  // Register writes are never held off.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind char_histogram_word_counter_top chw_checker u_chw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_count_i (out_o.count_value),
  .out_echo_i  (out_o.counter_echo)
);

@@ sim/char_histogram_word_counter_top_tb.sv @@
module char_histogram_word_counter_top_tb;
  import chw_pkg::*;

  // The clock runs with a period of 20 and reset is held low at the start.
  localparam int RESET_CYCLES = 7;
  // After the last expected result the bench waits on so that text, end and clear items that
  // are still queued inside the block drain before a register is rewritten.
  localparam int DRAIN_CYCLES = 12;
  // The receiver holds off for this long once, so that the four-entry queue fills.
  localparam int HOLD_CYCLES  = 300;
  // The run is abandoned if no handshake on any channel completes for this long.
  localparam int STALL_LIMIT  = 3000;
  // Random text is sent in six chunks, two per idling pattern.
  localparam int RANDOM_CHUNK = 270;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  chw_in_if  in_if ();
  chw_out_if out_if ();
  chw_cfg_if cfg_if ();

  char_histogram_word_counter_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  // One expected read result, as the block should return it.
  typedef struct {
    logic [OUT_W-1:0] value;
    logic [IDX_W-1:0] echo;
  } read_result_t;

  read_result_t pending_reads[$];

  // Our own copy of the registers and of the counting state.
  word_t                  word_reg [NUM_WORDS];
  logic [LENS_W-1:0]      len_reg;
  logic [COUNT_WIDTH-1:0] char_tally [HIST_ENTRIES];
  logic [COUNT_WIDTH-1:0] word_tally [NUM_WORDS];
  logic [BYTE_W-1:0]      recent [HIST_DEPTH];
  int unsigned            seen;

  int unsigned items_sent = 0;
  int unsigned err_count  = 0;
  int unsigned send_idle  = 17;
  int unsigned recv_idle  = 46;
  bit          hold_req   = 1'b0;
  int unsigned stall_cycles = 0;

  // ---------------------------------------------------------------------------------------
  // Prediction of the block's behaviour.
  // ---------------------------------------------------------------------------------------

  function automatic bit alpha_byte(logic [BYTE_W-1:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Counters stick at their maximum rather than wrapping.
  function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void forget_history();
    foreach (recent[j]) recent[j] = '0;
    seen = 0;
  endfunction

  function automatic void zero_tallies();
    foreach (char_tally[j]) char_tally[j] = '0;
    foreach (word_tally[j]) word_tally[j] = '0;
  endfunction

  // Counts every enabled word that ends at the newest history byte and is not preceded
  // by a letter. A length of zero or one above the longest allowed disables a word.
  function automatic void tally_words();
    int unsigned len;
    bit          hit;
    for (int w = 0; w < NUM_WORDS; w++) begin
      len = 32'(len_reg[3*w +: 3]);
      if (len == 0 || len > MAX_WORD_LEN || seen < len) continue;
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (recent[len-1-k] != word_reg[w][8*k +: 8]) hit = 1'b0;
      end
      if (hit && seen > len && alpha_byte(recent[len])) hit = 1'b0;
      if (hit) word_tally[w] = bump(word_tally[w]);
    end
  endfunction

  function automatic void predict_item(op_e op, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
    read_result_t res;
    case (op)
      OP_TEXT: begin
        if (b >= FIRST_PRINTABLE && b <= LAST_PRINTABLE)
          char_tally[b - FIRST_PRINTABLE] = bump(char_tally[b - FIRST_PRINTABLE]);
        // A non-letter closes any word that ended on the byte before it.
        if (!alpha_byte(b)) tally_words();
        for (int j = HIST_DEPTH - 1; j > 0; j--) recent[j] = recent[j-1];
        recent[0] = b;
        if (seen < HIST_DEPTH) seen++;
      end
      OP_END: begin
        // End of text closes a word on the last byte, and the next byte starts afresh.
        tally_words();
        forget_history();
      end
      OP_READ: begin
        res.value = '0;
        if (idx < HIST_ENTRIES) res.value = char_tally[idx];
        else if (idx < HIST_ENTRIES + NUM_WORDS) res.value = word_tally[idx - HIST_ENTRIES];
        res.echo = idx;
        pending_reads.push_back(res);
      end
      default: begin
        zero_tallies();
        forget_history();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving the channels.
  // ---------------------------------------------------------------------------------------

  // Offers one item, with a random gap beforehand, and returns once it is accepted. The
  // valid stays high on return so that back-to-back items need no second assignment.
  task automatic send_item(op_e op, logic [BYTE_W-1:0] b, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.data_byte     <= b;
    in_if.counter_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_item(op, b, idx);
    items_sent++;
  endtask

  // Lowers the item valid, waits for every expected result and lets the queue drain.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes one register. Indexes beyond the length register are ignored by the block.
  task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx < NUM_WORDS) word_reg[idx] = data;
    else if (idx == REG_LENGTHS) len_reg = data[LENS_W-1:0];
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] random_letter();
    int unsigned r;
    r = $urandom_range(51);
    return (r < 26) ? BYTE_W'("A" + r) : BYTE_W'("a" + r - 26);
  endfunction

  // Mostly a space, otherwise any non-letter including the non-printable codes.
  function automatic logic [BYTE_W-1:0] random_separator();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(1) == 0) begin
      c = 8'h20;
    end else begin
      do c = BYTE_W'($urandom_range(255)); while (alpha_byte(c));
    end
    return c;
  endfunction

  // Word counters are read most, then the histogram, then any index at all.
  function automatic logic [IDX_W-1:0] read_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return IDX_W'(HIST_ENTRIES + $urandom_range(NUM_WORDS - 1));
    if (r < 85) return IDX_W'($urandom_range(HIST_ENTRIES - 1));
    return IDX_W'($urandom_range(127));
  endfunction

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_TEXT, s[i], IDX_W'($urandom_range(127)));
  endtask

  task automatic read_word_counts();
    for (int i = HIST_ENTRIES; i <= HIST_ENTRIES + NUM_WORDS; i++)
      send_item(OP_READ, BYTE_W'($urandom_range(255)), IDX_W'(i));
  endtask

  // Sends the characters of a configured word, now and then cut short or with one
  // character changed, so that near misses occur as well as matches.
  task automatic send_word(int unsigned w);
    int unsigned       len;
    int unsigned       cut;
    logic [BYTE_W-1:0] c;
    len = 32'(len_reg[3*w +: 3]);
    if (len == 0 || len > MAX_WORD_LEN) len = $urandom_range(1, MAX_WORD_LEN);
    cut = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : len;
    for (int k = 0; k < cut; k++) begin
      c = word_reg[w][8*k +: 8];
      if ($urandom_range(14) == 0) c = random_letter();
      send_item(OP_TEXT, c, IDX_W'($urandom_range(127)));
    end
  endtask

  task automatic load_reset_words();
    for (int w = 0; w < NUM_WORDS; w++) cfg_write(CFG_AW'(w), WORD_RESET[w]);
    cfg_write(CFG_AW'(REG_LENGTHS), CFG_DW'(LENS_RESET));
  endtask

  // Random words, mostly letters, and random lengths with the odd disabled word. The
  // bytes beyond a word's length and the unused bits of the length register vary too.
  task automatic load_random_words();
    logic [CFG_DW-1:0] wd;
    logic [LENS_W-1:0] lens;
    for (int w = 0; w < NUM_WORDS; w++) begin
      wd = {16'($urandom), $urandom};
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        if ($urandom_range(3) != 0) wd[8*k +: 8] = random_letter();
      end
      cfg_write(CFG_AW'(w), wd);
    end
    for (int w = 0; w < NUM_WORDS; w++) begin
      if ($urandom_range(9) == 0) lens[3*w +: 3] = ($urandom_range(1) == 0) ? 3'd0 : 3'd7;
      else lens[3*w +: 3] = 3'($urandom_range(1, MAX_WORD_LEN));
    end
    wd = {16'($urandom), $urandom};
    wd[LENS_W-1:0] = lens;
    cfg_write(CFG_AW'(REG_LENGTHS), wd);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // With the reset words: a match at the start of text closed by end of text, a miss
  // behind a letter, a match closed by a non-printable byte, the histogram edges, reads
  // of every kind of index and a clear.
  task automatic test_directed();
    send_text("and");
    send_item(OP_END, 8'hFF, 7'h7F);
    send_text("bat");
    send_item(OP_TEXT, 8'h00, 7'h00);
    send_text("at");
    send_item(OP_TEXT, 8'hFF, 7'h7F);
    send_item(OP_TEXT, 8'd127, 7'h00);
    send_item(OP_TEXT, 8'd31, 7'h55);
    send_item(OP_TEXT, 8'd126, 7'h2A);
    send_item(OP_READ, 8'h00, IDX_W'(HIST_ENTRIES));
    send_item(OP_READ, 8'hFF, IDX_W'(HIST_ENTRIES + 1));
    send_item(OP_READ, 8'h00, 7'd0);
    send_item(OP_READ, 8'h00, IDX_W'(HIST_ENTRIES - 1));
    send_item(OP_READ, 8'h00, IDX_W'(HIST_ENTRIES + NUM_WORDS - 1));
    send_item(OP_READ, 8'h00, IDX_W'(HIST_ENTRIES + NUM_WORDS));
    send_item(OP_READ, 8'h00, 7'h7F);
    send_item(OP_CLEAR, 8'hFF, 7'h7F);
    send_item(OP_READ, 8'h00, IDX_W'(HIST_ENTRIES + 1));
    send_item(OP_READ, 8'h00, IDX_W'("a" - FIRST_PRINTABLE));
  endtask

  // Extreme register settings, each followed by a little text and reads of the word
  // counters. Writes to the unused register indexes must change nothing.
  task automatic test_config_extremes();
    // Every word all ones but every length zero, so nothing may count.
    wait_idle();
    for (int w = 0; w < NUM_WORDS; w++) cfg_write(CFG_AW'(w), '1);
    cfg_write(CFG_AW'(REG_LENGTHS), '0);
    repeat (3) send_item(OP_TEXT, 8'hFF, 7'h00);
    send_item(OP_END, 8'h00, 7'h00);
    read_word_counts();

    // Lengths of seven are above the limit and disable every word.
    wait_idle();
    for (int w = 0; w < NUM_WORDS; w++) cfg_write(CFG_AW'(w), '0);
    cfg_write(CFG_AW'(REG_LENGTHS), '1);
    repeat (3) send_item(OP_TEXT, 8'h00, 7'h7F);
    send_item(OP_END, 8'h00, 7'h00);
    read_word_counts();

    // Single-character words made of a non-letter byte.
    wait_idle();
    cfg_write(CFG_AW'(REG_LENGTHS), CFG_DW'({5{3'd1}}));
    send_item(OP_TEXT, 8'h00, 7'h00);
    send_item(OP_TEXT, 8'h20, 7'h00);
    send_text("a");
    send_item(OP_TEXT, 8'h00, 7'h00);
    send_item(OP_END, 8'h00, 7'h00);
    read_word_counts();

    // Words of the greatest length, one of them the name from the reset values.
    wait_idle();
    cfg_write(CFG_AW'(0), WORD_RESET[NUM_WORDS-1]);
    for (int w = 1; w < NUM_WORDS; w++) cfg_write(CFG_AW'(w), {16'($urandom), $urandom});
    cfg_write(CFG_AW'(REG_LENGTHS), CFG_DW'({5{3'd6}}));
    send_text("Hamlet");
    send_item(OP_END, 8'h00, 7'h00);
    send_text(" Hamlet! xHamlet Hamlets Hamle");
    send_item(OP_END, 8'h00, 7'h00);
    wait_idle();
    cfg_write(CFG_AW'(REG_LENGTHS + 1), {16'($urandom), $urandom});
    cfg_write(CFG_AW'(REG_LENGTHS + 2), '1);
    send_text(" Hamlet.");
    read_word_counts();
  endtask

  // The receiver stops for a long stretch while reads keep coming, so the queue fills
  // and the block has to hold its input back.
  task automatic test_backpressure();
    wait_idle();
    send_idle = 0;
    hold_req  = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_item(OP_READ, BYTE_W'($urandom_range(255)), read_index());
      else if (i % 3 == 1) send_item(OP_TEXT, random_letter(), IDX_W'($urandom_range(127)));
      else send_item(OP_TEXT, random_separator(), IDX_W'($urandom_range(127)));
    end
    wait_idle();
  endtask

  // Mostly text built from the configured words and separators, with letters and any
  // byte as noise, plus end of text, reads and the rare clear.
  task automatic random_stream(int unsigned n);
    int unsigned start_count;
    int unsigned r;
    start_count = items_sent;
    while (items_sent - start_count < n) begin
      r = $urandom_range(99);
      if (r < 30) send_word($urandom_range(NUM_WORDS - 1));
      else if (r < 55)
        send_item(OP_TEXT, random_separator(), IDX_W'($urandom_range(127)));
      else if (r < 75)
        send_item(OP_TEXT, random_letter(), IDX_W'($urandom_range(127)));
      else if (r < 83)
        send_item(OP_TEXT, BYTE_W'($urandom_range(255)), IDX_W'($urandom_range(127)));
      else if (r < 89)
        send_item(OP_END, BYTE_W'($urandom_range(255)), IDX_W'($urandom_range(127)));
      else if (r < 99)
        send_item(OP_READ, BYTE_W'($urandom_range(255)), read_index());
      else
        send_item(OP_CLEAR, BYTE_W'($urandom_range(255)), IDX_W'($urandom_range(127)));
    end
  endtask

  // Three idling patterns, each with two register settings.
  task automatic test_random_text();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 17;
          recv_idle = 46;
        end
        1: begin
          send_idle = 46;
          recv_idle = 17;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int chunk = 0; chunk < 2; chunk++) begin
        wait_idle();
        if (phase == 0 && chunk == 0) load_reset_words();
        else load_random_words();
        random_stream(RANDOM_CHUNK);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver, checker and watchdog.
  // ---------------------------------------------------------------------------------------

  // The receiver idles at random; on request it holds off for a fixed stretch.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Each accepted result is compared with the oldest expected one.
  always @(posedge clk_i) begin : check_results
    read_result_t head;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result: count_value %0d, counter_echo %0d",
               out_if.count_value, out_if.counter_echo);
        err_count++;
      end else begin
        head = pending_reads.pop_front();
        if (out_if.count_value !== head.value) begin
          $error("count_value: expected %0d, got %0d", head.value, out_if.count_value);
          err_count++;
        end
        if (out_if.counter_echo !== head.echo) begin
          $error("counter_echo: expected %0d, got %0d", head.echo, out_if.counter_echo);
          err_count++;
        end
      end
    end
  end

  // Any completed handshake shows progress; a long stretch without one is a hang.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL char_histogram_word_counter_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------------------

  initial begin
    in_if.valid         <= 1'b0;
    in_if.operation     <= OP_TEXT;
    in_if.data_byte     <= '0;
    in_if.counter_index <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;

    foreach (word_reg[w]) word_reg[w] = WORD_RESET[w];
    len_reg = LENS_RESET;
    zero_tallies();
    forget_history();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Saturation cannot be reached in a run of this length, so it is not aimed at.
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_text();

    wait_idle();
    if (err_count == 0) begin
      $display("PASS char_histogram_word_counter_top");
    end else begin
      $display("FAIL char_histogram_word_counter_top");
    end
    $finish;
  end

endmodule
